// File: design/hqf_pkg.sv
// Shared types and constants for the histogram quantile finder.
// Used by the front, queue, back and top-level modules; depends on nothing.

package hqf_pkg;

  localparam int NUM_LEVELS = 7;
  localparam int LVL_W      = 3;
  localparam int THR_W      = 32;
  localparam int FIELD_W    = 32;
  localparam int QDEPTH     = 2;
  localparam int QPTR_W     = 1;
  localparam int QCNT_W     = 2;

  localparam logic [LVL_W-1:0] LAST_LEVEL = LVL_W'(NUM_LEVELS - 1);
  localparam logic [LVL_W-1:0] CFG_LIMIT  = LVL_W'(NUM_LEVELS);

  localparam logic [THR_W-1:0] THR_RESET [NUM_LEVELS] = '{
    32'd6442451, 32'd107374182, 32'd687194767, 32'd2147483648,
    32'd3607772529, 32'd4187593114, 32'd4288524845
  };

  typedef struct packed {
    logic [FIELD_W-1:0]    coord;
    logic [FIELD_W-1:0]    prob;
    logic [NUM_LEVELS-1:0] hit;
    logic                  first;
    logic                  last;
  } hqf_item_t;

  typedef struct packed {
    logic full;
    logic empty;
  } hqf_q_status_t;

endpackage

// File: design/hqf_front.sv
// Front end: accepts bins, keeps the saturating running sum and thresholds,
// and marks which levels are first reached by each bin. Depends on hqf_pkg.

module hqf_front import hqf_pkg::*; #(
  parameter int PROB_BITS = 32
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic signed [FIELD_W-1:0] in_bin_coord,
  input  logic [FIELD_W-1:0]        in_bin_prob,
  input  logic                      in_last_bin,
  input  logic                      cfg_wr_en,
  input  logic [LVL_W-1:0]          cfg_index,
  input  logic [THR_W-1:0]          cfg_wr_data,
  input  hqf_q_status_t             q_status,
  output logic                      push,
  output hqf_item_t                 push_item
);

  localparam int SW = PROB_BITS + 1;
  localparam int PW = (PROB_BITS < FIELD_W) ? PROB_BITS : FIELD_W;
  localparam int UP = (PROB_BITS >= THR_W) ? PROB_BITS - THR_W : 0;
  localparam int DN = (PROB_BITS < THR_W) ? THR_W - PROB_BITS : 0;
  localparam int WW = THR_W + SW;
  localparam logic [WW-1:0] LOW_DN = (WW'(1) << DN) - WW'(1);
  localparam logic [SW-1:0] ONE    = SW'(1) << PROB_BITS;

  function automatic logic [SW-1:0] scale_thr(input logic [THR_W-1:0] t);
    logic [WW-1:0] w;
    w = WW'(t);
    if (PROB_BITS >= THR_W) begin
      w = w << UP;
    end else begin
      w = (w + LOW_DN) >> DN;
    end
    return w[SW-1:0];
  endfunction

  logic [SW-1:0]         thr_r [NUM_LEVELS];
  logic [SW-1:0]         sum_r, sum_nxt;
  logic [NUM_LEVELS-1:0] hit_r, hit_nxt;
  logic                  first_r, first_nxt;
  logic [SW-1:0]         sum_add, sum_sat;
  logic [PW-1:0]         prob_k;
  logic [NUM_LEVELS-1:0] new_hit;

  assign in_stall = q_status.full;
  assign push     = in_valid && !q_status.full;
  assign prob_k   = in_bin_prob[PW-1:0];
  assign sum_add  = sum_r + SW'(prob_k);
  assign sum_sat  = (sum_add > ONE) ? ONE : sum_add;

  always_comb begin
    for (int k = 0; k < NUM_LEVELS; k++) begin
      new_hit[k] = !hit_r[k] && (sum_sat >= thr_r[k]);
    end
    push_item.coord = in_bin_coord;
    push_item.prob  = FIELD_W'(prob_k);
    push_item.hit   = new_hit;
    push_item.first = first_r;
    push_item.last  = in_last_bin;
    sum_nxt   = sum_r;
    hit_nxt   = hit_r;
    first_nxt = first_r;
    if (push) begin
      if (in_last_bin) begin
        sum_nxt   = '0;
        hit_nxt   = '0;
        first_nxt = 1'b1;
      end else begin
        sum_nxt   = sum_sat;
        hit_nxt   = hit_r | new_hit;
        first_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_r   <= '0;
      hit_r   <= '0;
      first_r <= 1'b1;
      for (int k = 0; k < NUM_LEVELS; k++) begin
        thr_r[k] <= scale_thr(THR_RESET[k]);
      end
    end else begin
      sum_r   <= sum_nxt;
      hit_r   <= hit_nxt;
      first_r <= first_nxt;
      if (cfg_wr_en && (cfg_index < CFG_LIMIT)) begin
        thr_r[cfg_index] <= scale_thr(cfg_wr_data);
      end
    end
  end

endmodule

// File: design/hqf_queue.sv
// Short queue of classified bins between the front and back ends.
// Depends on hqf_pkg for the item and status types.

module hqf_queue import hqf_pkg::*; (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  hqf_item_t     push_item,
  input  logic          pop,
  output hqf_item_t     pop_item,
  output hqf_q_status_t status
);

  hqf_item_t         mem_r [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [QCNT_W-1:0] count_r, count_nxt;
  logic              do_push, do_pop;

  assign status.full  = (count_r == QCNT_W'(QDEPTH));
  assign status.empty = (count_r == '0);
  assign do_push      = push && !status.full;
  assign do_pop       = pop && !status.empty;
  assign pop_item     = mem_r[rd_ptr_r];

  always_comb begin
    count_nxt = count_r;
    if (do_push && !do_pop) begin
      count_nxt = count_r + QCNT_W'(1);
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - QCNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_item;
    end
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      count_r <= count_nxt;
      if (do_push) begin
        wr_ptr_r <= wr_ptr_r + QPTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr_r <= rd_ptr_r + QPTR_W'(1);
      end
    end
  end

endmodule

// File: design/hqf_back.sv
// Back end: latches each level's crossing bin, snapshots the seven results
// on the last bin into a bank and streams them out. Depends on hqf_pkg.

module hqf_back import hqf_pkg::*; #(
  parameter int PROB_BITS  = 32,
  parameter int COORD_BITS = 32
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  hqf_q_status_t             q_status,
  input  hqf_item_t                 pop_item,
  output logic                      pop,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic [LVL_W-1:0]          out_level_index,
  output logic signed [FIELD_W-1:0] out_level_coord,
  output logic [FIELD_W-1:0]        out_level_prob,
  output logic                      out_level_found,
  output logic                      out_last_result
);

  localparam int PW = (PROB_BITS < FIELD_W) ? PROB_BITS : FIELD_W;
  localparam int CW = (COORD_BITS < FIELD_W) ? COORD_BITS : FIELD_W;

  logic [NUM_LEVELS-1:0] found_r;
  logic [CW-1:0]         st_coord_r [NUM_LEVELS];
  logic [PW-1:0]         st_prob_r  [NUM_LEVELS];
  logic [CW-1:0]         first_coord_r;
  logic [CW-1:0]         bank_coord_r [NUM_LEVELS];
  logic [PW-1:0]         bank_prob_r  [NUM_LEVELS];
  logic [NUM_LEVELS-1:0] bank_found_r;
  logic                  busy_r;
  logic [LVL_W-1:0]      idx_r;
  logic                  out_valid_r;
  logic [LVL_W-1:0]      out_index_r;
  logic signed [CW-1:0]  out_coord_r;
  logic [PW-1:0]         out_prob_r;
  logic                  out_found_r, out_last_r;

  logic [CW-1:0]         item_coord, first_n;
  logic [PW-1:0]         item_prob;
  logic [NUM_LEVELS-1:0] hit_n;
  logic                  load;

  assign pop        = !q_status.empty && (!pop_item.last || !busy_r);
  assign item_coord = pop_item.coord[CW-1:0];
  assign item_prob  = pop_item.prob[PW-1:0];
  assign first_n    = pop_item.first ? item_coord : first_coord_r;
  assign hit_n      = found_r | pop_item.hit;
  assign load       = busy_r && (!out_valid_r || !out_stall);

  always_ff @(posedge clk) begin
    if (pop) begin
      if (pop_item.first) begin
        first_coord_r <= item_coord;
      end
      for (int k = 0; k < NUM_LEVELS; k++) begin
        if (pop_item.hit[k]) begin
          st_coord_r[k] <= item_coord;
          st_prob_r[k]  <= item_prob;
        end
        if (pop_item.last) begin
          bank_found_r[k] <= hit_n[k];
          if (pop_item.hit[k]) begin
            bank_coord_r[k] <= item_coord;
            bank_prob_r[k]  <= item_prob;
          end else if (found_r[k]) begin
            bank_coord_r[k] <= st_coord_r[k];
            bank_prob_r[k]  <= st_prob_r[k];
          end else begin
            bank_coord_r[k] <= first_n;
            bank_prob_r[k]  <= '0;
          end
        end
      end
    end
    if (load) begin
      out_index_r <= idx_r;
      out_coord_r <= bank_coord_r[idx_r];
      out_prob_r  <= bank_prob_r[idx_r];
      out_found_r <= bank_found_r[idx_r];
      out_last_r  <= (idx_r == LAST_LEVEL);
    end
    if (!rst_n) begin
      found_r     <= '0;
      busy_r      <= 1'b0;
      idx_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (pop) begin
        found_r <= pop_item.last ? '0 : hit_n;
      end
      if (pop && pop_item.last) begin
        busy_r <= 1'b1;
      end else if (load && (idx_r == LAST_LEVEL)) begin
        busy_r <= 1'b0;
      end
      if (load) begin
        idx_r <= (idx_r == LAST_LEVEL) ? '0 : idx_r + LVL_W'(1);
      end
      if (load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_valid       = out_valid_r;
  assign out_level_index = out_index_r;
  assign out_level_coord = FIELD_W'(out_coord_r);
  assign out_level_prob  = FIELD_W'(out_prob_r);
  assign out_level_found = out_found_r;
  assign out_last_result = out_last_r;

endmodule

// File: design/histogram_quantile_finder_core.sv
// Top level of the histogram quantile finder: front, queue and back ends.
// Depends on hqf_pkg, hqf_front, hqf_queue and hqf_back.
//
//   Channel  Handshake            Payload
//   in       in_valid/in_stall    in_bin_coord, in_bin_prob, in_last_bin
//   out      out_valid/out_stall  out_level_index/_coord/_prob/_found, out_last_result
//   cfg      cfg_wr_en            cfg_index, cfg_wr_data
//
// One bin is accepted per cycle while the queue is not full; the sum, add and seven
// compares sit in the front end. A last bin yields seven results from a result bank.
// A further last bin waits in the queue until the seventh result has left the bank.
// Reset restores the default thresholds and clears the run; there is no clearing pass.

module histogram_quantile_finder_core import hqf_pkg::*; #(
  parameter int PROB_BITS  = 32,
  parameter int COORD_BITS = 32
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic signed [FIELD_W-1:0] in_bin_coord,
  input  logic [FIELD_W-1:0]        in_bin_prob,
  input  logic                      in_last_bin,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic [LVL_W-1:0]          out_level_index,
  output logic signed [FIELD_W-1:0] out_level_coord,
  output logic [FIELD_W-1:0]        out_level_prob,
  output logic                      out_level_found,
  output logic                      out_last_result,
  input  logic                      cfg_wr_en,
  input  logic [LVL_W-1:0]          cfg_index,
  input  logic [THR_W-1:0]          cfg_wr_data
);

  hqf_q_status_t q_status;
  hqf_item_t     push_item, pop_item;
  logic          push, pop;

  hqf_front #(.PROB_BITS(PROB_BITS)) u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_bin_coord (in_bin_coord),
    .in_bin_prob  (in_bin_prob),
    .in_last_bin  (in_last_bin),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_index    (cfg_index),
    .cfg_wr_data  (cfg_wr_data),
    .q_status     (q_status),
    .push         (push),
    .push_item    (push_item)
  );

  hqf_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_item (push_item),
    .pop       (pop),
    .pop_item  (pop_item),
    .status    (q_status)
  );

  hqf_back #(.PROB_BITS(PROB_BITS), .COORD_BITS(COORD_BITS)) u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .q_status        (q_status),
    .pop_item        (pop_item),
    .pop             (pop),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_level_index (out_level_index),
    .out_level_coord (out_level_coord),
    .out_level_prob  (out_level_prob),
    .out_level_found (out_level_found),
    .out_last_result (out_last_result)
  );

  a_next_level: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_stall && !out_last_result
      |=> out_valid && (out_level_index == $past(out_level_index) + LVL_W'(1)))
    else $error("result levels did not follow in order");

  a_last_marks_top: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_last_result == (out_level_index == LAST_LEVEL)))
    else $error("last result flag does not match the level index");

  a_unfound_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_level_found |-> (out_level_prob == '0))
    else $error("level not reached but probability is nonzero");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall
      |=> out_valid && $stable(out_level_index) && $stable(out_level_coord) &&
          $stable(out_level_prob) && $stable(out_level_found) &&
          $stable(out_last_result))
    else $error("stalled result changed before its transfer");

endmodule
